// ===== rtl/core/dilp_pkg.sv =====
`default_nettype none

package dilp_pkg;

    localparam int MAX_DELIMS = 4;
    localparam int DELIM_REGS = 4;
    localparam int DELIM_LIM  = (MAX_DELIMS < DELIM_REGS) ? MAX_DELIMS : DELIM_REGS;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    localparam logic [2:0] REG_DELIM_COUNT = 3'd0;
    localparam logic [2:0] REG_DELIM_0     = 3'd1;
    localparam logic [2:0] REG_DELIM_1     = 3'd2;
    localparam logic [2:0] REG_DELIM_2     = 3'd3;
    localparam logic [2:0] REG_DELIM_3     = 3'd4;
    localparam logic [2:0] REG_SKIP_EMPTY  = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [2:0]                  delim_count;
        logic [DELIM_REGS-1:0][7:0]  delim;
        logic                        skip_empty;
    } t_cfg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_string;
    } t_item;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic               overflowed;
        logic               last_field;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/dilp_if.sv =====
`default_nettype none

interface dilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_string;

    modport source (output valid, output char_byte, output has_char, output end_of_string,
                    input ready);
    modport sink   (input valid, input char_byte, input has_char, input end_of_string,
                    output ready);
endinterface

interface dilp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field_value;
    logic               overflowed;
    logic               last_field;

    modport source (output valid, output field_value, output overflowed, output last_field,
                    input ready);
    modport sink   (input valid, input field_value, input overflowed, input last_field,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dilp_field.sv =====
`default_nettype none

module dilp_field
    import dilp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_go,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_push o_push
);

    logic        r_empty;
    t_phase      r_phase;
    logic        r_neg;
    logic [31:0] r_mag;
    logic        r_sat;

    logic        n_empty;
    t_phase      n_phase;
    logic        n_neg;
    logic [31:0] n_mag;
    logic        n_sat;

    // state after the byte is taken, before any end of string
    logic        m_empty;
    t_phase      m_phase;
    logic        m_neg;
    logic [31:0] m_mag;
    logic        m_sat;

    logic        is_delim;
    logic        is_digit;
    logic        is_space;
    logic        do_acc;
    logic [31:0] limit;
    logic [35:0] acc;
    logic        e0_valid;
    logic        e1_valid;
    t_result     e0;
    t_result     e1;
    logic [7:0]  c;

    assign c        = i_item.char_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);

    always_comb begin
        is_delim = 1'b0;
        for (int i = 0; i < DELIM_REGS; i++) begin
            if ((i < DELIM_LIM) && (32'(i_cfg.delim_count) > 32'(i))
                && (i_cfg.delim[i] == c)) begin
                is_delim = 1'b1;
            end
        end
    end

    always_comb begin
        m_empty = r_empty;
        m_phase = r_phase;
        m_neg   = r_neg;
        m_mag   = r_mag;
        m_sat   = r_sat;
        do_acc  = 1'b0;
        if (i_item.has_char && is_delim) begin
            m_empty = 1'b1;
            m_phase = PH_SKIP;
            m_neg   = 1'b0;
            m_mag   = '0;
            m_sat   = 1'b0;
        end else if (i_item.has_char) begin
            m_empty = 1'b0;
            unique case (r_phase)
                PH_SKIP: begin
                    if (is_space) begin
                        m_phase = PH_SKIP;
                    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        m_neg   = (c == CH_MINUS);
                        m_phase = PH_DIGITS;
                    end else begin
                        m_phase = is_digit ? PH_DIGITS : PH_DONE;
                        do_acc  = is_digit;
                    end
                end
                PH_DIGITS: begin
                    m_phase = is_digit ? PH_DIGITS : PH_DONE;
                    do_acc  = is_digit;
                end
                default: begin
                    m_phase = r_phase;
                end
            endcase
        end

        // magnitude * 10 + digit, saturated at the limit for the sign
        limit = r_neg ? NEG_LIMIT : POS_LIMIT;
        acc   = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {32'b0, c[3:0] - CH_ZERO[3:0]};
        if (do_acc) begin
            if (acc > {4'b0, limit}) begin
                m_mag = limit;
                m_sat = 1'b1;
            end else begin
                m_mag = acc[31:0];
            end
        end
    end

    always_comb begin
        e0.field_value = $signed(r_neg ? (32'd0 - r_mag) : r_mag);
        e0.overflowed  = r_sat;
        e0.last_field  = 1'b0;
        e1.field_value = $signed(m_neg ? (32'd0 - m_mag) : m_mag);
        e1.overflowed  = m_sat;
        e1.last_field  = 1'b1;

        e0_valid = i_go && i_item.has_char && is_delim && !(i_cfg.skip_empty && r_empty);
        e1_valid = i_go && i_item.end_of_string && !(i_cfg.skip_empty && m_empty);

        o_push.count = {e0_valid & e1_valid, e0_valid ^ e1_valid};
        o_push.slot0 = e0_valid ? e0 : e1;
        o_push.slot1 = e1;

        if (i_item.end_of_string) begin
            n_empty = 1'b1;
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_mag   = '0;
            n_sat   = 1'b0;
        end else begin
            n_empty = m_empty;
            n_phase = m_phase;
            n_neg   = m_neg;
            n_mag   = m_mag;
            n_sat   = m_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b1;
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_sat   <= 1'b0;
        end else if (i_go) begin
            r_empty <= n_empty;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_sat   <= n_sat;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.end_of_string) |=> (r_empty && (r_phase == PH_SKIP) && !r_sat))
        else $error("field state not cleared after end of string");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_mag == (r_neg ? NEG_LIMIT : POS_LIMIT)))
        else $error("saturated magnitude not at its limit");

    a_two_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (i_go && i_item.has_char && i_item.end_of_string))
        else $error("two words from an item without delimiter and end of string");

endmodule

`default_nettype wire

// ===== rtl/core/dilp_fifo.sv =====
`default_nettype none

module dilp_fifo
    import dilp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    dilp_out_if.source o_out
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;

    logic [FIFO_AW-1:0]   wr_1;
    logic [FIFO_AW-1:0]   wr_2;
    logic                 pop;
    t_result              head;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        return (32'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign wr_1 = ptr_inc(r_wr);
    assign wr_2 = ptr_inc(wr_1);
    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rd];

    // room for the worst case of two words from one item
    assign o_room = (32'(r_count) <= FIFO_DEPTH - 2);

    assign o_out.valid       = (r_count != '0);
    assign o_out.field_value = head.field_value;
    assign o_out.overflowed  = head.overflowed;
    assign o_out.last_field  = head.last_field;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_1] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            priority case (i_push.count)
                2'd1:    r_wr <= wr_1;
                2'd2:    r_wr <= wr_2;
                default: r_wr <= r_wr;
            endcase
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_count <= r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(i_push.count)) <= FIFO_DEPTH)
        else $error("result queue overrun");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_count != '0))
        else $error("result queue read while empty");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |=> o_out.valid)
        else $error("pushed word not presented");

endmodule

`default_nettype wire

// ===== rtl/core/delimited_integer_list_parser.sv =====
// Delimited integer list parser.
// Input channel i_in carries one character word (char_byte, has_char,
// end_of_string); a word is taken at a clock edge with valid and ready high.
// Each field between delimiter bytes is converted as atoi would, saturating
// to the int32 limits with overflowed set. Output channel o_out carries one
// field word (field_value, overflowed, last_field) under the same handshake.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, one
// register per edge, by the user only while no string is in flight; the
// block itself does not enforce this. A field word passes the input
// register and the conversion in front of the result queue, and is valid
// once the queue holds it. Throughput: one input word per cycle while the
// queue has room; a word that yields two fields is written as two entries.
// A four-entry result queue decouples the sides; the input register holds
// its word, and ready drops, while the queue has room for fewer than two
// fields, so a stalled receiver backs up the input within a few words.
// Reset (synchronous, active low) restores the default delimiter set,
// clears the field state and empties the queue.
`default_nettype none

module delimited_integer_list_parser
    import dilp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [7:0]  i_cfg_data,
    dilp_in_if.sink    i_in,
    dilp_out_if.source o_out
);

    t_cfg  r_cfg;
    logic  r_in_valid;
    t_item r_in;

    logic  room;
    logic  go;
    t_push push;

    assign go         = r_in_valid && room;
    assign i_in.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim_count <= 3'd1;
            r_cfg.delim       <= {24'd0, 8'd44};
            r_cfg.skip_empty  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELIM_COUNT: r_cfg.delim_count <= i_cfg_data[2:0];
                REG_DELIM_0:     r_cfg.delim[0]    <= i_cfg_data;
                REG_DELIM_1:     r_cfg.delim[1]    <= i_cfg_data;
                REG_DELIM_2:     r_cfg.delim[2]    <= i_cfg_data;
                REG_DELIM_3:     r_cfg.delim[3]    <= i_cfg_data;
                REG_SKIP_EMPTY:  r_cfg.skip_empty  <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.char_byte     <= i_in.char_byte;
            r_in.has_char      <= i_in.has_char;
            r_in.end_of_string <= i_in.end_of_string;
        end
    end

    dilp_field u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_push  (push)
    );

    dilp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
